>>> rtl/tfwm_pkg.sv
// Shared constants and types for the topic filter wildcard matcher.
package tfwm_pkg;

   localparam int MAX_FILTER_LEN = 64;

   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_PLUS  = 8'h2B;

   typedef enum logic [1:0] {
      MODE_CLEAR  = 2'd0,
      MODE_APPEND = 2'd1,
      MODE_NAME   = 2'd2,
      MODE_QUERY  = 2'd3
   } mode_type;

   // registered read side of the filter store
   typedef struct packed {
      logic [7:0] cur_byte;      // filter byte at the cursor
      logic [7:0] run_end_byte;  // first non-plus byte after the plus run at the cursor
      logic       run_open;      // plus run at the cursor reaches the filter tail
      logic [7:0] tail1;         // last stored filter byte
      logic [7:0] tail2;         // second to last stored filter byte
   } store_rd_type;

endpackage

>>> rtl/tfwm_store.sv
// Filter byte memory, plus-run end table and filter tail registers.
module tfwm_store #(
   parameter int MAX_LEN = tfwm_pkg::MAX_FILTER_LEN,
   localparam int AW = $clog2(MAX_LEN)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   clear,
   input  logic                   wr_en,
   input  logic [AW-1:0]          wr_idx,
   input  logic [7:0]             wr_byte,
   input  logic [AW-1:0]          rd_addr,
   output logic [AW-1:0]          rd_run_end,
   output tfwm_pkg::store_rd_type rd
);

   logic [7:0]    byte_mem [MAX_LEN];
   logic [AW+7:0] run_mem  [MAX_LEN];

   logic          open_ff, open_in;
   logic [AW-1:0] open_rs_ff, open_rs_in;
   logic          close_run;
   logic [AW+7:0] run_wdata;

   logic [7:0]    cur_byte_ff;
   logic [AW+7:0] run_rd_ff;
   logic          run_open_ff;
   logic [7:0]    tail1_ff, tail2_ff;

   // a run of plus bytes is tracked by its start; it closes on the next other byte
   always_comb begin
      close_run  = wr_en && (wr_byte != tfwm_pkg::CH_PLUS) && open_ff;
      run_wdata  = {wr_idx, wr_byte};
      open_in    = open_ff;
      open_rs_in = open_rs_ff;
      if (clear) begin
         open_in = 1'b0;
      end else if (wr_en) begin
         if (wr_byte == tfwm_pkg::CH_PLUS) begin
            open_in = 1'b1;
            if (!open_ff) begin
               open_rs_in = wr_idx;
            end
         end else begin
            open_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         byte_mem[wr_idx] <= wr_byte;
      end
      if (wr_en && (wr_idx == rd_addr)) begin
         cur_byte_ff <= wr_byte;
      end else begin
         cur_byte_ff <= byte_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (close_run) begin
         run_mem[open_rs_ff] <= run_wdata;
      end
      if (close_run && (open_rs_ff == rd_addr)) begin
         run_rd_ff <= run_wdata;
      end else begin
         run_rd_ff <= run_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff     <= 1'b0;
         run_open_ff <= 1'b0;
      end else begin
         open_ff     <= open_in;
         run_open_ff <= open_in && (open_rs_in == rd_addr);
      end
   end

   always_ff @(posedge clock) begin
      open_rs_ff <= open_rs_in;
      if (wr_en) begin
         tail2_ff <= tail1_ff;
         tail1_ff <= wr_byte;
      end
   end

   assign rd_run_end      = run_rd_ff[AW+7:8];
   assign rd.cur_byte     = cur_byte_ff;
   assign rd.run_end_byte = run_rd_ff[7:0];
   assign rd.run_open     = run_open_ff;
   assign rd.tail1        = tail1_ff;
   assign rd.tail2        = tail2_ff;

endmodule

>>> rtl/topic_filter_wildcard_match_core.sv
// Top level of the topic filter wildcard matcher.
//
// Holds one topic filter of up to MAX_FILTER_LEN bytes and matches streamed
// topic names against it, with '+' and '#' wildcards unless exact_only is
// set. A new word is taken in every cycle while the result register is free
// or being drained; the verdict is registered in the result register in the
// cycle after the name's last word or the empty-name query. In the filter
// store, the byte at the cursor and the end of the plus run there come from
// two memories read at the next cursor with registered data, and the filter
// tail sits in registers for the end-of-filter checks. Clear and append
// words give no result. Memories need no clearing pass: only entries below
// the fill count are read.
module topic_filter_wildcard_match_core #(
   parameter int MAX_FILTER_LEN = tfwm_pkg::MAX_FILTER_LEN
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [7:0] char_code, [8] exact_only, rest zero
   input  logic [1:0]  req_tuser,   // [1:0] mode
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata    // [0] match, [1] filter_overflow, rest zero
);

   localparam int AW = $clog2(MAX_FILTER_LEN);
   localparam int CW = $clog2(MAX_FILTER_LEN + 1);

   function automatic logic tail_hit(input logic [CW-1:0] pos, input logic [CW-1:0] cnt,
                                     input logic [7:0] t1, input logic [7:0] t2);
      logic [CW:0] p2;
      logic [CW:0] p3;
      p2 = {1'b0, pos} + (CW+1)'(2);
      p3 = {1'b0, pos} + (CW+1)'(3);
      // filter ends in "/#" or "+" right after the matched byte
      return ((p3 == {1'b0, cnt}) && (t2 == tfwm_pkg::CH_SLASH) && (t1 == tfwm_pkg::CH_HASH))
          || ((p2 == {1'b0, cnt}) && (t1 == tfwm_pkg::CH_PLUS));
   endfunction

   logic [CW-1:0] count_ff, count_in;
   logic          overflow_ff, overflow_in;
   logic [CW-1:0] cursor_ff, cursor_in;
   logic          skip_ff, skip_in;
   logic          decided_ff, decided_in;
   logic          dval_ff, dval_in;
   logic          held_v_ff, held_v_in;
   logic [CW-1:0] held_q_ff, held_q_in;
   logic [7:0]    held_qb_ff, held_qb_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_match_ff, rsp_match_in;
   logic          rsp_ovf_ff, rsp_ovf_in;

   logic                   accept;
   tfwm_pkg::mode_type     mode;
   logic [7:0]             c;
   logic                   exact;
   logic                   is_last;
   logic                   wr_en;
   logic                   clear;
   logic                   emit;
   logic                   emit_v;
   logic [AW-1:0]          store_q;
   tfwm_pkg::store_rd_type rd;
   logic [7:0]             f;
   logic                   in_filter;
   logic [CW-1:0]          run_q;
   logic [7:0]             run_qb;
   logic [CW-1:0]          cursor_p1;
   logic                   adv_held_v;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign mode       = tfwm_pkg::mode_type'(req_tuser);
   assign c          = req_tdata[7:0];
   assign exact      = req_tdata[8];
   assign is_last    = req_tlast;

   tfwm_store #(
      .MAX_LEN (MAX_FILTER_LEN)
   ) u_store (
      .clock      (clock),
      .reset      (reset),
      .clear      (clear),
      .wr_en      (wr_en),
      .wr_idx     (count_ff[AW-1:0]),
      .wr_byte    (c),
      .rd_addr    (cursor_in[AW-1:0]),
      .rd_run_end (store_q),
      .rd         (rd)
   );

   // a cursor inside a plus run keeps the run end it saw at the run start
   assign f          = rd.cur_byte;
   assign in_filter  = cursor_ff < count_ff;
   assign run_q      = held_v_ff ? held_q_ff : (rd.run_open ? count_ff : CW'(store_q));
   assign run_qb     = held_v_ff ? held_qb_ff : rd.run_end_byte;
   assign cursor_p1  = cursor_ff + CW'(1);
   assign adv_held_v = in_filter && (f == tfwm_pkg::CH_PLUS) && (cursor_p1 < run_q);

   always_comb begin
      count_in     = count_ff;
      overflow_in  = overflow_ff;
      cursor_in    = cursor_ff;
      skip_in      = skip_ff;
      decided_in   = decided_ff;
      dval_in      = dval_ff;
      held_v_in    = held_v_ff;
      held_q_in    = held_q_ff;
      held_qb_in   = held_qb_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_match_in = rsp_match_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      wr_en        = 1'b0;
      clear        = 1'b0;
      emit         = 1'b0;
      emit_v       = 1'b0;
      if (accept) begin
         case (mode)
            tfwm_pkg::MODE_CLEAR: begin
               count_in    = '0;
               overflow_in = 1'b0;
               clear       = 1'b1;
            end
            tfwm_pkg::MODE_APPEND: begin
               if (count_ff < CW'(MAX_FILTER_LEN)) begin
                  wr_en    = 1'b1;
                  count_in = count_ff + CW'(1);
               end else begin
                  overflow_in = 1'b1;
               end
            end
            tfwm_pkg::MODE_QUERY: begin
               emit   = 1'b1;
               emit_v = (count_ff == '0);
            end
            tfwm_pkg::MODE_NAME: begin
               if (!decided_ff) begin
                  if (exact) begin
                     if (in_filter && (f == c)) begin
                        cursor_in  = cursor_p1;
                        held_v_in  = adv_held_v;
                        held_q_in  = run_q;
                        held_qb_in = run_qb;
                     end else begin
                        decided_in = 1'b1;
                        dval_in    = 1'b0;
                     end
                  end else if (skip_ff && (c != tfwm_pkg::CH_SLASH)) begin
                     skip_in = skip_ff;
                  end else begin
                     skip_in = 1'b0;
                     if (!in_filter) begin
                        decided_in = 1'b1;
                        dval_in    = 1'b0;
                     end else if (c == f) begin
                        if (is_last && tail_hit(cursor_ff, count_ff, rd.tail1, rd.tail2)) begin
                           decided_in = 1'b1;
                           dval_in    = 1'b1;
                        end else begin
                           cursor_in  = cursor_p1;
                           held_v_in  = adv_held_v;
                           held_q_in  = run_q;
                           held_qb_in = run_qb;
                        end
                     end else if (f == tfwm_pkg::CH_PLUS) begin
                        if (c == tfwm_pkg::CH_SLASH) begin
                           // slash skips the whole plus run as empty levels
                           if (run_q >= count_ff) begin
                              decided_in = 1'b1;
                              dval_in    = 1'b0;
                           end else if (run_qb == tfwm_pkg::CH_SLASH) begin
                              if (is_last && tail_hit(run_q, count_ff, rd.tail1, rd.tail2)) begin
                                 decided_in = 1'b1;
                                 dval_in    = 1'b1;
                              end else begin
                                 cursor_in = run_q + CW'(1);
                                 held_v_in = 1'b0;
                              end
                           end else begin
                              decided_in = 1'b1;
                              dval_in    = (run_qb == tfwm_pkg::CH_HASH);
                           end
                        end else begin
                           cursor_in  = cursor_p1;
                           held_v_in  = adv_held_v;
                           held_q_in  = run_q;
                           held_qb_in = run_qb;
                           skip_in    = 1'b1;
                        end
                     end else begin
                        decided_in = 1'b1;
                        dval_in    = (f == tfwm_pkg::CH_HASH);
                     end
                  end
               end
               if (is_last) begin
                  emit   = 1'b1;
                  emit_v = decided_in ? dval_in : (cursor_in == count_ff);
               end
            end
            default: ;
         endcase
         if (emit) begin
            rsp_valid_in = 1'b1;
            rsp_match_in = emit_v && !overflow_ff;
            rsp_ovf_in   = overflow_ff;
         end
         // every word but a mid-name byte ends the name in progress
         if (emit || (mode != tfwm_pkg::MODE_NAME)) begin
            cursor_in  = '0;
            skip_in    = 1'b0;
            decided_in = 1'b0;
            dval_in    = 1'b0;
            held_v_in  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         overflow_ff  <= 1'b0;
         cursor_ff    <= '0;
         skip_ff      <= 1'b0;
         decided_ff   <= 1'b0;
         dval_ff      <= 1'b0;
         held_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         overflow_ff  <= overflow_in;
         cursor_ff    <= cursor_in;
         skip_ff      <= skip_in;
         decided_ff   <= decided_in;
         dval_ff      <= dval_in;
         held_v_ff    <= held_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      held_q_ff    <= held_q_in;
      held_qb_ff   <= held_qb_in;
      rsp_match_ff <= rsp_match_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_ovf_ff, rsp_match_ff};

endmodule

>>> tb/sv/topic_filter_wildcard_match_checker.sv
`timescale 1ns / 1ps
// Predicts and checks verdicts of the topic filter matcher from its two streams.
module topic_filter_wildcard_match_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [15:0] req_tdata,   // [7:0] char_code, [8] exact_only, rest zero
   input  logic [1:0]  req_tuser,   // [1:0] mode
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [7:0]  rsp_tdata,   // [0] match, [1] filter_overflow, rest zero
   output int          mismatches,
   output int          verdicts_pending,
   output int          verdicts_seen,
   output int          matches_seen,
   output int          overflows_seen
);

   typedef struct packed {
      logic match;
      logic overflow;
   } verdict_type;

   verdict_type verdict_q[$];

   logic [7:0]  filter_mem [tfwm_pkg::MAX_FILTER_LEN];
   int unsigned filter_len;
   int unsigned cursor;
   bit          skip_level;
   bit          settled;
   bit          settled_val;
   bit          overflow_seen;

   int n_bad  = 0;
   int n_seen = 0;
   int n_hit  = 0;
   int n_ovf  = 0;

   function automatic void restart_name();
      cursor      = 0;
      skip_level  = 0;
      settled     = 0;
      settled_val = 0;
   endfunction

   function automatic void settle_to(bit v);
      settled     = 1;
      settled_val = v;
   endfunction

   function automatic void push_verdict(bit m);
      verdict_type v;
      v.match    = m && !overflow_seen;
      v.overflow = overflow_seen;
      verdict_q.push_back(v);
      restart_name();
   endfunction

   function automatic void step_exact(logic [7:0] c);
      if (cursor < filter_len && filter_mem[cursor] == c) cursor++;
      else settle_to(0);
   endfunction

   function automatic void step_wild(logic [7:0] c, bit is_last);
      bit         again;
      logic [7:0] f;
      again = 1;
      while (again) begin
         again = 0;
         if (skip_level) begin
            if (c != tfwm_pkg::CH_SLASH) return;
            skip_level = 0;
         end
         if (cursor >= filter_len) begin
            settle_to(0);
            return;
         end
         f = filter_mem[cursor];
         if (c == f) begin
            // "x/#" also takes "x", and "x/+" also takes "x/"
            if (is_last && cursor + 3 == filter_len &&
                filter_mem[cursor + 1] == tfwm_pkg::CH_SLASH &&
                filter_mem[cursor + 2] == tfwm_pkg::CH_HASH) begin
               settle_to(1);
               return;
            end
            if (is_last && cursor + 2 == filter_len &&
                filter_mem[cursor + 1] == tfwm_pkg::CH_PLUS) begin
               settle_to(1);
               return;
            end
            cursor++;
            return;
         end
         if (f == tfwm_pkg::CH_PLUS) begin
            cursor++;
            // empty level under '+': the slash is compared again at the next filter byte
            if (c == tfwm_pkg::CH_SLASH) again = 1;
            else skip_level = 1;
         end else begin
            settle_to(f == tfwm_pkg::CH_HASH);
         end
      end
   endfunction

   function automatic void take_word(tfwm_pkg::mode_type mode, logic [7:0] c, bit is_last,
                                     bit exact);
      case (mode)
         tfwm_pkg::MODE_CLEAR: begin
            filter_len    = 0;
            overflow_seen = 0;
            restart_name();
         end
         tfwm_pkg::MODE_APPEND: begin
            if (filter_len < tfwm_pkg::MAX_FILTER_LEN) begin
               filter_mem[filter_len] = c;
               filter_len++;
            end else begin
               overflow_seen = 1;
            end
            restart_name();
         end
         tfwm_pkg::MODE_QUERY: push_verdict(filter_len == 0);
         default: begin
            if (!settled) begin
               if (exact) step_exact(c);
               else step_wild(c, is_last);
            end
            if (is_last) begin
               if (settled) push_verdict(settled_val);
               else push_verdict(cursor == filter_len);
            end
         end
      endcase
   endfunction

   always @(posedge clock) begin
      verdict_type want;
      if (reset) begin
         filter_len    = 0;
         overflow_seen = 0;
         restart_name();
         verdict_q.delete();
      end else begin
         // request first: a verdict leaving at this edge is always older
         if (req_tvalid && req_tready)
            take_word(tfwm_pkg::mode_type'(req_tuser), req_tdata[7:0], req_tlast,
                      req_tdata[8]);
         if (rsp_tvalid && rsp_tready) begin
            n_seen++;
            if (rsp_tdata[0]) n_hit++;
            if (rsp_tdata[1]) n_ovf++;
            if (verdict_q.size() == 0) begin
               n_bad++;
               if (n_bad <= 10)
                  $display("%0t: verdict word with none pending: match=%0b overflow=%0b",
                           $realtime, rsp_tdata[0], rsp_tdata[1]);
            end else begin
               want = verdict_q.pop_front();
               if (rsp_tdata[0] !== want.match || rsp_tdata[1] !== want.overflow) begin
                  n_bad++;
                  if (n_bad <= 10)
                     $display("%0t: mismatch: want match=%0b ovf=%0b, got match=%0b ovf=%0b",
                              $realtime, want.match, want.overflow, rsp_tdata[0],
                              rsp_tdata[1]);
               end
            end
         end
      end
      mismatches       <= n_bad;
      verdicts_pending <= verdict_q.size();
      verdicts_seen    <= n_seen;
      matches_seen     <= n_hit;
      overflows_seen   <= n_ovf;
   end

endmodule

>>> tb/sv/topic_filter_wildcard_match_core_tb.sv
`timescale 1ns / 1ps
// Stimulus and verdict for the topic filter matcher: filters, topic names and flow control.
module topic_filter_wildcard_match_core_tb;

   localparam int WORD_TARGET  = 1350;
   localparam int LIMIT_CYCLES = 200000;
   localparam int DRAIN_CYCLES = 10;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;   // [7:0] char_code, [8] exact_only, rest zero
   logic [1:0]  req_tuser  = tfwm_pkg::MODE_CLEAR;   // [1:0] mode
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;   // [0] match, [1] filter_overflow, rest zero

   int mismatches, verdicts_pending, verdicts_seen, matches_seen, overflows_seen;

   int cycle_count  = 0;
   int words_sent   = 0;
   int filters_made = 0;
   int burst_left   = 0;
   int stall_style  = 0;

   topic_filter_wildcard_match_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   topic_filter_wildcard_match_checker u_check (
      .clock            (clock),
      .reset            (reset),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tdata        (req_tdata),
      .req_tuser        (req_tuser),
      .req_tlast        (req_tlast),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata),
      .mismatches       (mismatches),
      .verdicts_pending (verdicts_pending),
      .verdicts_seen    (verdicts_seen),
      .matches_seen     (matches_seen),
      .overflows_seen   (overflows_seen)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("simulation failed");
         $finish;
      end
   end

   // receiver: picks one of four stall styles for rsp_tready and redraws it at random
   always @(posedge clock) begin
      if (cycle_count % 128 == 0) stall_style = $urandom_range(0, 3);
      case (stall_style)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= 1'($urandom_range(0, 1));
         2: rsp_tready <= ($urandom_range(0, 4) == 0);
         default: rsp_tready <= (cycle_count % 5 < 3);
      endcase
   end

   // bytes weighted toward topic structure; plain excludes the level separator
   function automatic logic [7:0] pick_char(bit plain);
      int r;
      r = $urandom_range(0, 99);
      if (r < 35) return $urandom_range(0, 1) ? "a" : "b";
      if (r < 55 && !plain) return tfwm_pkg::CH_SLASH;
      if (r < 67) return tfwm_pkg::CH_PLUS;
      if (r < 75) return tfwm_pkg::CH_HASH;
      if (r < 80) return $urandom_range(0, 1) ? 8'h00 : 8'hFF;
      r = $urandom_range(0, 255);
      if (plain && r == tfwm_pkg::CH_SLASH) r = "c";
      return 8'(r);
   endfunction

   task automatic send_word(input tfwm_pkg::mode_type mode, input logic [7:0] ch,
                            input logic last_w, input logic exact_w);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {7'b0, exact_w, ch};
      req_tlast  <= last_w;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      words_sent++;
   endtask

   initial begin
      logic [7:0] filter_q[$];
      logic [7:0] name_q[$];
      logic [7:0] c;
      int         target_len, kind, n;
      bit         exact, dropped;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: empty filter, tail wildcards, exact compare, extreme bytes, dropped name
      send_word(tfwm_pkg::MODE_QUERY, 8'h00, 1'b0, 1'b0);
      send_word(tfwm_pkg::MODE_NAME, "a", 1'b1, 1'b0);
      send_word(tfwm_pkg::MODE_APPEND, "a", 1'b0, 1'b0);
      send_word(tfwm_pkg::MODE_APPEND, tfwm_pkg::CH_SLASH, 1'b0, 1'b0);
      send_word(tfwm_pkg::MODE_APPEND, tfwm_pkg::CH_HASH, 1'b0, 1'b0);
      send_word(tfwm_pkg::MODE_NAME, "a", 1'b1, 1'b0);
      send_word(tfwm_pkg::MODE_NAME, "a", 1'b0, 1'b0);
      send_word(tfwm_pkg::MODE_NAME, tfwm_pkg::CH_SLASH, 1'b0, 1'b0);
      send_word(tfwm_pkg::MODE_NAME, "z", 1'b1, 1'b0);
      send_word(tfwm_pkg::MODE_CLEAR, 8'hFF, 1'b1, 1'b1);
      send_word(tfwm_pkg::MODE_APPEND, "a", 1'b0, 1'b0);
      send_word(tfwm_pkg::MODE_APPEND, tfwm_pkg::CH_SLASH, 1'b0, 1'b0);
      send_word(tfwm_pkg::MODE_APPEND, tfwm_pkg::CH_PLUS, 1'b0, 1'b0);
      send_word(tfwm_pkg::MODE_NAME, "a", 1'b0, 1'b0);
      send_word(tfwm_pkg::MODE_NAME, tfwm_pkg::CH_SLASH, 1'b1, 1'b0);
      send_word(tfwm_pkg::MODE_NAME, "a", 1'b0, 1'b1);
      send_word(tfwm_pkg::MODE_NAME, tfwm_pkg::CH_SLASH, 1'b0, 1'b1);
      send_word(tfwm_pkg::MODE_NAME, tfwm_pkg::CH_PLUS, 1'b1, 1'b1);
      send_word(tfwm_pkg::MODE_APPEND, 8'hFF, 1'b1, 1'b1);
      send_word(tfwm_pkg::MODE_NAME, 8'h00, 1'b1, 1'b0);
      send_word(tfwm_pkg::MODE_QUERY, 8'hFF, 1'b1, 1'b1);
      send_word(tfwm_pkg::MODE_NAME, "a", 1'b0, 1'b0);
      send_word(tfwm_pkg::MODE_CLEAR, 8'h00, 1'b0, 1'b0);
      filter_q.delete();

      while (words_sent < WORD_TARGET) begin
         filters_made++;
         if ($urandom_range(0, 9) != 0) begin
            send_word(tfwm_pkg::MODE_CLEAR, 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            filter_q.delete();
         end
         // every twelfth filter runs near or past capacity
         target_len = filter_q.size() +
                      ((filters_made % 12 == 0) ? $urandom_range(60, 72) : $urandom_range(0, 7));
         n = filter_q.size();
         while (filter_q.size() < target_len) begin
            if (filter_q.size() > 0) filter_q.push_back(tfwm_pkg::CH_SLASH);
            kind = $urandom_range(0, 9);
            if (kind < 2) filter_q.push_back(tfwm_pkg::CH_PLUS);
            else if (kind == 2) filter_q.push_back(tfwm_pkg::CH_HASH);
            else if (kind == 3) filter_q.push_back(pick_char(1'b0));
            else repeat ($urandom_range(1, 3)) filter_q.push_back(pick_char(1'b1));
         end
         for (int i = n; i < filter_q.size(); i++)
            send_word(tfwm_pkg::MODE_APPEND, filter_q[i], 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));

         repeat ($urandom_range(1, 6)) begin
            exact = ($urandom_range(0, 3) == 0);
            name_q.delete();
            foreach (filter_q[i]) begin
               if (!exact && filter_q[i] == tfwm_pkg::CH_PLUS) begin
                  repeat ($urandom_range(0, 2)) name_q.push_back(pick_char(1'b1));
               end else if (!exact && filter_q[i] == tfwm_pkg::CH_HASH) begin
                  if ($urandom_range(0, 2) == 0 && name_q.size() > 0 &&
                      name_q[$] == tfwm_pkg::CH_SLASH)
                     void'(name_q.pop_back());
                  else
                     repeat ($urandom_range(0, 4)) name_q.push_back(pick_char(1'b0));
               end else begin
                  name_q.push_back(filter_q[i]);
               end
            end
            case ($urandom_range(0, 9))
               0: begin
                  if (name_q.size() > 0)
                     name_q[$urandom_range(0, name_q.size() - 1)] = pick_char(1'b0);
               end
               1: name_q.push_back(pick_char(1'b0));
               2: if (name_q.size() > 0) void'(name_q.pop_back());
               3: begin
                  name_q.delete();
                  repeat ($urandom_range(1, 6)) name_q.push_back(pick_char(1'b0));
               end
               default: ;
            endcase

            if (name_q.size() == 0) begin
               send_word(tfwm_pkg::MODE_QUERY, 8'($urandom_range(0, 255)),
                         1'($urandom_range(0, 1)), exact);
            end else begin
               dropped = 0;
               foreach (name_q[i]) begin
                  if (!dropped) begin
                     if ($urandom_range(0, 19) == 0) exact = !exact;
                     send_word(tfwm_pkg::MODE_NAME, name_q[i], i == name_q.size() - 1, exact);
                     // occasionally cut the name short with a filter edit or a query
                     if (i != name_q.size() - 1 && $urandom_range(0, 29) == 0) begin
                        dropped = 1;
                        c = 8'($urandom_range(0, 255));
                        case ($urandom_range(0, 2))
                           0: begin
                              send_word(tfwm_pkg::MODE_CLEAR, c, 1'($urandom_range(0, 1)),
                                        1'($urandom_range(0, 1)));
                              filter_q.delete();
                           end
                           1: begin
                              send_word(tfwm_pkg::MODE_APPEND, c, 1'($urandom_range(0, 1)),
                                        1'($urandom_range(0, 1)));
                              filter_q.push_back(c);
                           end
                           default:
                              send_word(tfwm_pkg::MODE_QUERY, c, 1'($urandom_range(0, 1)),
                                        1'($urandom_range(0, 1)));
                        endcase
                     end
                  end
               end
            end
         end
      end

      req_tvalid <= 1'b0;
      while (verdicts_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d words over %0d filters in %0d cycles", words_sent, filters_made,
               cycle_count);
      $display("checked %0d verdicts: %0d matches, %0d with filter overflow", verdicts_seen,
               matches_seen, overflows_seen);
      if (mismatches == 0 && verdicts_pending == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/tfwm_pkg.sv
rtl/tfwm_store.sv
rtl/topic_filter_wildcard_match_core.sv
tb/sv/topic_filter_wildcard_match_checker.sv
tb/sv/topic_filter_wildcard_match_core_tb.sv
